@@ hw/rtl/ptl_pkg.sv @@
// shared widths and types for the point to line distance datapath
package ptl_pkg;

	// coordinate width and everything derived from it
	localparam int CW    = 32;
	localparam int DW    = CW + 1;
	localparam int PW    = 2 * DW;
	localparam int XW    = PW + 1;
	localparam int MW    = PW;
	localparam int LOW   = (MW + 1) / 2;
	localparam int HIW   = MW - LOW;
	localparam int SW    = 2 * MW;
	localparam int NW    = SW + 2;
	localparam int DENW  = PW + 2;
	localparam int QW    = CW;
	localparam int DSHFT = 2 * (QW - 1);

	typedef logic signed [CW-1:0] coord_t;

	typedef struct packed {
		coord_t ax;
		coord_t ay;
		coord_t az;
		coord_t bx;
		coord_t by;
		coord_t bz;
		coord_t cx;
		coord_t cy;
		coord_t cz;
	} points_t;

	// front end result: squared cross norm over squared segment length
	typedef struct packed {
		logic            valid;
		logic [NW-1:0]   num;
		logic [DENW-1:0] den;
		logic            deg;
	} ratio_t;

	// state handed from one root cell to the next
	typedef struct packed {
		logic          valid;
		logic [NW-1:0] rem;
		logic [NW-1:0] ps;
		logic [NW-1:0] ds;
		logic [QW-1:0] root;
		logic          deg;
	} cell_t;

endpackage

@@ hw/rtl/ptl_query_if.sv @@
// query channel: two line points and a query point
interface ptl_query_if;
	logic            valid;
	logic            ready;
	ptl_pkg::coord_t line_a_x;
	ptl_pkg::coord_t line_a_y;
	ptl_pkg::coord_t line_a_z;
	ptl_pkg::coord_t line_b_x;
	ptl_pkg::coord_t line_b_y;
	ptl_pkg::coord_t line_b_z;
	ptl_pkg::coord_t query_x;
	ptl_pkg::coord_t query_y;
	ptl_pkg::coord_t query_z;

	modport source (
		output valid, line_a_x, line_a_y, line_a_z, line_b_x, line_b_y, line_b_z,
		output query_x, query_y, query_z,
		input  ready
	);
	modport sink (
		input  valid, line_a_x, line_a_y, line_a_z, line_b_x, line_b_y, line_b_z,
		input  query_x, query_y, query_z,
		output ready
	);
endinterface

@@ hw/rtl/ptl_result_if.sv @@
// result channel: distance and degenerate flag
interface ptl_result_if;
	logic                      valid;
	logic                      ready;
	logic [ptl_pkg::QW-1:0]    distance;
	logic                      degenerate;

	modport source (output valid, distance, degenerate, input ready);
	modport sink (input valid, distance, degenerate, output ready);
endinterface

@@ hw/rtl/ptl_front.sv @@
// front end pipeline: differences, cross product, squared norms
module ptl_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             valid,
	input  ptl_pkg::points_t pts,
	output ptl_pkg::ratio_t  ratio
);
	logic signed [ptl_pkg::DW-1:0] ab_s1 [3];
	logic signed [ptl_pkg::DW-1:0] ac_s1 [3];
	logic signed [ptl_pkg::PW-1:0] xp_s2 [6];
	logic        [ptl_pkg::PW-1:0] ab2_s2 [3];
	logic signed [ptl_pkg::XW-1:0] cr_s3 [3];
	logic        [ptl_pkg::MW-1:0] mag_s4 [3];
	logic [2*ptl_pkg::HIW-1:0]          hh_s5 [3];
	logic [ptl_pkg::HIW+ptl_pkg::LOW-1:0] hl_s5 [3];
	logic [2*ptl_pkg::LOW-1:0]          ll_s5 [3];
	logic        [ptl_pkg::SW-1:0] sq_s6 [3];
	logic        [ptl_pkg::NW-1:0] num_s7;
	logic [ptl_pkg::DENW-1:0] den_s3, den_s4, den_s5, den_s6, den_s7;
	logic [7:1] vld_q;
	logic [7:3] deg_q;
	ptl_pkg::coord_t a [3];
	ptl_pkg::coord_t b [3];
	ptl_pkg::coord_t c [3];
	logic [ptl_pkg::DENW-1:0] den_c;

	assign a = '{pts.ax, pts.ay, pts.az};
	assign b = '{pts.bx, pts.by, pts.bz};
	assign c = '{pts.cx, pts.cy, pts.cz};
	assign den_c = ptl_pkg::DENW'(ab2_s2[0]) + ptl_pkg::DENW'(ab2_s2[1])
		+ ptl_pkg::DENW'(ab2_s2[2]);

	// valid flags along the stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[6:1], valid};
		end
	end

	// arithmetic stages
	always_ff @(posedge clk) begin
		if (en) begin
			// s1: edge vectors
			for (int i = 0; i < 3; i++) begin
				ab_s1[i] <= ptl_pkg::DW'(b[i]) - ptl_pkg::DW'(a[i]);
				ac_s1[i] <= ptl_pkg::DW'(c[i]) - ptl_pkg::DW'(a[i]);
			end
			// s2: cross product terms and segment squares
			xp_s2[0] <= ab_s1[1] * ac_s1[2];
			xp_s2[1] <= ab_s1[2] * ac_s1[1];
			xp_s2[2] <= ab_s1[2] * ac_s1[0];
			xp_s2[3] <= ab_s1[0] * ac_s1[2];
			xp_s2[4] <= ab_s1[0] * ac_s1[1];
			xp_s2[5] <= ab_s1[1] * ac_s1[0];
			for (int i = 0; i < 3; i++) begin
				ab2_s2[i] <= ptl_pkg::PW'(ab_s1[i]) * ptl_pkg::PW'(ab_s1[i]);
			end
			// s3: cross product, squared length
			for (int i = 0; i < 3; i++) begin
				cr_s3[i] <= ptl_pkg::XW'(xp_s2[2*i]) - ptl_pkg::XW'(xp_s2[2*i+1]);
			end
			den_s3 <= den_c;
			deg_q[3] <= (den_c == '0);
			// s4: magnitudes
			for (int i = 0; i < 3; i++) begin
				mag_s4[i] <= cr_s3[i][ptl_pkg::XW-1] ? ptl_pkg::MW'(-cr_s3[i])
					: ptl_pkg::MW'(cr_s3[i]);
			end
			den_s4 <= den_s3;
			// s5: partial products of the squares
			for (int i = 0; i < 3; i++) begin
				hh_s5[i] <= mag_s4[i][ptl_pkg::MW-1:ptl_pkg::LOW]
					* mag_s4[i][ptl_pkg::MW-1:ptl_pkg::LOW];
				hl_s5[i] <= mag_s4[i][ptl_pkg::MW-1:ptl_pkg::LOW]
					* mag_s4[i][ptl_pkg::LOW-1:0];
				ll_s5[i] <= mag_s4[i][ptl_pkg::LOW-1:0] * mag_s4[i][ptl_pkg::LOW-1:0];
			end
			den_s5 <= den_s4;
			// s6: component squares
			for (int i = 0; i < 3; i++) begin
				sq_s6[i] <= (ptl_pkg::SW'(hh_s5[i]) << (2 * ptl_pkg::LOW))
					+ (ptl_pkg::SW'(hl_s5[i]) << (ptl_pkg::LOW + 1))
					+ ptl_pkg::SW'(ll_s5[i]);
			end
			den_s6 <= den_s5;
			// s7: squared cross norm
			num_s7 <= ptl_pkg::NW'(sq_s6[0]) + ptl_pkg::NW'(sq_s6[1])
				+ ptl_pkg::NW'(sq_s6[2]);
			den_s7 <= den_s6;
			deg_q[7:4] <= deg_q[6:3];
		end
	end

	assign ratio.valid = vld_q[7];
	assign ratio.num   = num_s7;
	assign ratio.den   = den_s7;
	assign ratio.deg   = deg_q[7];

endmodule

@@ hw/rtl/ptl_cell.sv @@
// one root cell: decides one result bit and hands the residue on
module ptl_cell (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  ptl_pkg::cell_t up,
	output ptl_pkg::cell_t down
);
	logic [ptl_pkg::NW-1:0] delta;
	logic [ptl_pkg::NW-1:0] ps_sel;
	logic                   take;
	logic                   valid_q;
	ptl_pkg::cell_t         data_q;

	// trial: (2q+1 at this weight) times the divisor against the residue
	always_comb begin
		delta  = up.ps + up.ds;
		take   = (delta <= up.rem);
		ps_sel = take ? up.ps + (up.ds << 1) : up.ps;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= up.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			data_q.valid <= up.valid;
			data_q.rem   <= take ? up.rem - delta : up.rem;
			data_q.ps    <= ps_sel >> 1;
			data_q.ds    <= up.ds >> 2;
			data_q.root  <= {up.root[ptl_pkg::QW-2:0], take};
			data_q.deg   <= up.deg;
		end
	end

	always_comb begin
		down       = data_q;
		down.valid = valid_q;
	end

endmodule

@@ hw/rtl/point_to_line_distance_3d.sv @@
// Distance from a query point to the line through two points, in 3D. Takes one
// query beat per clock cycle while ready is high and returns one result beat
// for each, in order. 7 stages form the cross product and squared norms
// exactly, then a chain of 32 identical cells each settles one bit of
// floor(sqrt(|AB x AC|^2 / |AB|^2)) by shift-and-subtract. A two-entry output
// queue lets the pipeline keep taking queries while a result waits; ready drops
// only when that queue is full. The distance saturates at all ones; when both
// line points coincide, degenerate is set and distance is 0.
module point_to_line_distance_3d (
	input  logic                clk,
	input  logic                arst_n,
	ptl_query_if.sink           query,
	ptl_result_if.source        result
);
	logic             en;
	ptl_pkg::points_t pts;
	ptl_pkg::ratio_t  ratio;
	ptl_pkg::cell_t   chain [ptl_pkg::QW+1];
	logic [ptl_pkg::QW-1:0] dist_q [2];
	logic             deg_q [2];
	logic [1:0]       cnt_q;
	logic             wr_q;
	logic             rd_q;
	logic             push;
	logic             pop;
	ptl_pkg::cell_t   last;

	// pipeline moves whenever the output queue has room
	assign en          = (cnt_q != 2'd2);
	assign query.ready = en;

	assign pts = '{ax: query.line_a_x, ay: query.line_a_y, az: query.line_a_z,
		bx: query.line_b_x, by: query.line_b_y, bz: query.line_b_z,
		cx: query.query_x, cy: query.query_y, cz: query.query_z};

	ptl_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.valid  (query.valid),
		.pts    (pts),
		.ratio  (ratio)
	);

	// root chain entry: divisor scaled to the top result bit
	always_comb begin
		chain[0].valid = ratio.valid;
		chain[0].rem   = ratio.num;
		chain[0].ps    = '0;
		chain[0].ds    = ptl_pkg::NW'(ratio.den) << ptl_pkg::DSHFT;
		chain[0].root  = '0;
		chain[0].deg   = ratio.deg;
	end

	for (genvar i = 0; i < ptl_pkg::QW; i++) begin : g_cell
		ptl_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.up     (chain[i]),
			.down   (chain[i+1])
		);
	end

	assign last = chain[ptl_pkg::QW];
	assign push = en && last.valid;
	assign pop  = result.valid && result.ready;

	// output queue control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (pop) begin
				rd_q <= ~rd_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	// output queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			dist_q[wr_q] <= last.deg ? '0 : last.root;
			deg_q[wr_q]  <= last.deg;
		end
	end

	assign result.valid      = (cnt_q != 2'd0);
	assign result.distance   = dist_q[rd_q];
	assign result.degenerate = deg_q[rd_q];

`ifndef SYNTHESIS
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3)
		else $error("output queue count out of range");
	a_deg_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.degenerate |-> result.distance == '0)
		else $error("degenerate beat with nonzero distance");
	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q == 2'd2 && !result.ready |=> cnt_q == 2'd2)
		else $error("full queue changed without a pop");
	a_ptr_sync: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 2'd1) == (wr_q != rd_q))
		else $error("queue pointers disagree with count");
`endif

endmodule

@@ tb/tb_point_to_line_distance_3d.sv @@
// testbench for point_to_line_distance_3d: random and directed queries against a wide-integer model
`timescale 1ns / 1ps

module tb_point_to_line_distance_3d;

	typedef struct packed {
		logic [ptl_pkg::QW-1:0] distance;
		logic                   degenerate;
	} dist_t;

	// exact distance from the query point to the line, truncated root of |AB x AC|^2 / |AB|^2
	function automatic dist_t line_distance(ptl_pkg::points_t p);
		logic signed [199:0] abx, aby, abz, acx, acy, acz, crx, cry, crz;
		logic [199:0] num, den, lhs, t;
		logic [ptl_pkg::QW-1:0] q;
		dist_t r;
		abx = $signed(p.bx) - $signed(p.ax);
		aby = $signed(p.by) - $signed(p.ay);
		abz = $signed(p.bz) - $signed(p.az);
		acx = $signed(p.cx) - $signed(p.ax);
		acy = $signed(p.cy) - $signed(p.ay);
		acz = $signed(p.cz) - $signed(p.az);
		crx = aby * acz - abz * acy;
		cry = abz * acx - abx * acz;
		crz = abx * acy - aby * acx;
		num = crx * crx + cry * cry + crz * crz;
		den = abx * abx + aby * aby + abz * abz;
		r.degenerate = (den == 0);
		q = '0;
		if (!r.degenerate) begin
			for (int b = ptl_pkg::QW - 1; b >= 0; b--) begin
				t = {168'b0, q | (32'd1 << b)};
				lhs = t * t * den;
				if (lhs <= num)
					q = t[ptl_pkg::QW-1:0];
			end
		end
		r.distance = q;
		return r;
	endfunction

	// expected distances waiting for their result beats
	class distance_board;
		dist_t pending[$];
		int    errors;

		function void note(ptl_pkg::points_t p);
			pending.push_back(line_distance(p));
		endfunction

		function void check(logic [ptl_pkg::QW-1:0] distance, logic degenerate);
			dist_t e;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result distance=%h degenerate=%b",
					$time, distance, degenerate);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (distance !== e.distance) begin
				$display("%0t: distance expected %h actual %h", $time, e.distance, distance);
				errors++;
			end
			if (degenerate !== e.degenerate) begin
				$display("%0t: degenerate expected %b actual %b", $time, e.degenerate,
					degenerate);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	bit   idling;
	distance_board board;

	ptl_query_if  query_bus ();
	ptl_result_if result_bus ();

	point_to_line_distance_3d i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.query  (query_bus),
		.result (result_bus)
	);

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	// send one query beat, with an occasional idle burst in front
	task automatic send_query(ptl_pkg::points_t p);
		if (idling && $urandom_range(0, 7) == 0) begin
			query_bus.valid = 1'b0;
			repeat ($urandom_range(1, 15)) @(negedge clk);
		end
		query_bus.line_a_x = p.ax;
		query_bus.line_a_y = p.ay;
		query_bus.line_a_z = p.az;
		query_bus.line_b_x = p.bx;
		query_bus.line_b_y = p.by;
		query_bus.line_b_z = p.bz;
		query_bus.query_x  = p.cx;
		query_bus.query_y  = p.cy;
		query_bus.query_z  = p.cz;
		query_bus.valid    = 1'b1;
		do @(posedge clk); while (!query_bus.ready);
		board.note(p);
		@(negedge clk);
	endtask

	function automatic ptl_pkg::coord_t small_coord();
		return ptl_pkg::coord_t'($signed($urandom_range(0, 32'h1FFFFF)) - 32'sh100000);
	endfunction

	// random query: full range, small range, coinciding line points, b_x one above a_x or a point on the line
	function automatic ptl_pkg::points_t random_query();
		ptl_pkg::points_t p;
		int k;
		p = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
			$urandom, $urandom, $urandom};
		case ($urandom_range(0, 9))
			0, 1, 2: ;
			3, 4, 5: begin
				p.ax = small_coord(); p.ay = small_coord(); p.az = small_coord();
				p.bx = small_coord(); p.by = small_coord(); p.bz = small_coord();
				p.cx = small_coord(); p.cy = small_coord(); p.cz = small_coord();
			end
			6: begin
				p.bx = p.ax; p.by = p.ay; p.bz = p.az;
			end
			7: begin
				p.bx = p.ax + 1;
			end
			default: begin
				p.ax = small_coord(); p.ay = small_coord(); p.az = small_coord();
				p.bx = p.ax + ($urandom_range(0, 511) - 256);
				p.by = p.ay + ($urandom_range(0, 511) - 256);
				p.bz = p.az + ($urandom_range(0, 511) - 256);
				k = $urandom_range(0, 200) - 100;
				p.cx = p.ax + k * (p.bx - p.ax);
				p.cy = p.ay + k * (p.by - p.ay);
				p.cz = p.az + k * (p.bz - p.az);
			end
		endcase
		return p;
	endfunction

	// result side: ready drops in random bursts while idling is on
	initial begin
		int hold;
		hold = 0;
		result_bus.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold > 0) begin
				hold--;
				result_bus.ready = 1'b0;
			end else if (idling && $urandom_range(0, 9) == 0) begin
				hold = $urandom_range(1, 15) - 1;
				result_bus.ready = 1'b0;
			end else begin
				result_bus.ready = 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && result_bus.valid && result_bus.ready)
			board.check(result_bus.distance, result_bus.degenerate);
	end

	initial begin
		#20_000_000;
		$display("[point_to_line_distance_3d] ERROR");
		$finish;
	end

	initial begin
		localparam ptl_pkg::coord_t MX = 32'sh7FFFFFFF;
		localparam ptl_pkg::coord_t MN = 32'sh80000000;
		ptl_pkg::points_t directed[$];
		int      wait_cycles;
		board = new();
		idling = 1'b1;
		arst_n = 1'b0;
		query_bus.valid = 1'b0;
		{query_bus.line_a_x, query_bus.line_a_y, query_bus.line_a_z} = '0;
		{query_bus.line_b_x, query_bus.line_b_y, query_bus.line_b_z} = '0;
		{query_bus.query_x, query_bus.query_y, query_bus.query_z} = '0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// field extremes, coinciding points, point on the line, saturation
		directed.push_back({MX, MX, MX, MX, MX, MX, MX, MX, MX});
		directed.push_back({MN, MN, MN, MN, MN, MN, MN, MN, MN});
		directed.push_back({MN, MN, MN, MX, MX, MX, MX, MN, MX});
		directed.push_back({MX, MX, MX, MN, MN, MN, MN, MX, MN});
		directed.push_back({32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0,
			32'sd0, 32'sd0, 32'sd0});
		directed.push_back({32'sd5, 32'sd6, 32'sd7, 32'sd5, 32'sd6, 32'sd7,
			MX, MN, MX});
		directed.push_back({32'sd0, MN, MN, 32'sd1, MN, MN, 32'sd0, MX, MX});
		directed.push_back({MN, 32'sd0, 32'sd0, MX, 32'sd0, 32'sd0, 32'sd0, MX, MX});
		directed.push_back({32'sd0, 32'sd0, 32'sd0, 32'sh10000, 32'sd0, 32'sd0,
			32'sh50000, 32'sh30000, 32'sh40000});
		directed.push_back({32'sd0, 32'sd0, 32'sd0, 32'sh10000, 32'sh10000, 32'sh10000,
			32'sh30000, 32'sh30000, 32'sh30000});
		directed.push_back({32'sd1, 32'sd2, 32'sd3, 32'sd1, 32'sd2, 32'sd3,
			32'sd1, 32'sd2, 32'sd3});
		directed.push_back({MN, MX, MN, MX, MN, MX, MN, MX, MN});
		directed.push_back({32'sd0, 32'sd0, 32'sd0, 32'sd1, 32'sd0, 32'sd0,
			32'sd0, 32'sd1, 32'sd0});
		directed.push_back({32'sh12345678, -32'sh0ABCDEF0, 32'sh7F00FF00,
			-32'sh12345678, 32'sh0ABCDEF0, -32'sh7F00FF00, 32'sd0, 32'sd0, 32'sd0});
		foreach (directed[i])
			send_query(directed[i]);

		for (int n = 0; n < 1650; n++) begin
			if (n == 800) begin
				// let the pipeline drain completely before going on
				query_bus.valid = 1'b0;
				while (board.pending.size() != 0)
					@(negedge clk);
			end
			if (n == 1450)
				idling = 1'b0;
			send_query(random_query());
		end
		query_bus.valid = 1'b0;

		wait_cycles = 0;
		while (board.pending.size() != 0 && wait_cycles < 10000) begin
			@(negedge clk);
			wait_cycles++;
		end
		repeat (50) @(negedge clk);
		if (board.errors == 0 && board.pending.size() == 0) begin
			$display("[point_to_line_distance_3d] OK");
		end else begin
			if (board.pending.size() != 0)
				$display("%0t: %0d results never arrived", $time, board.pending.size());
			$display("[point_to_line_distance_3d] ERROR");
		end
		$finish;
	end

endmodule
